// ===== hdl/qbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Quoted block tokenizer package
// Shared constants, state codes and the result record of the tokenizer.
// ----------------------------------------------------------------------------
package qbt_pkg;

	localparam int LEVEL_BITS = 8;
	localparam int REP_W = (LEVEL_BITS + 1 > 9) ? LEVEL_BITS + 1 : 9;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {{(LEVEL_BITS-1){1'b1}}, 1'b0};

	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_KEY   = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		TOK_KEY   = 3'd0,
		TOK_VALUE = 3'd1,
		TOK_BLOCK = 3'd2,
		TOK_SEMI  = 3'd3,
		TOK_EQ    = 3'd4
	} tok_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] out_char;
		logic       token_done;
		logic [2:0] token_type;
		logic [7:0] token_level;
	} res_t;

endpackage

// ===== hdl/quoted_block_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Quoted block tokenizer
// Streams one character per request in and emits echoed token characters and
// token completions with their type and nesting level.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while s_axis_tready is high
// and gives at most one result per character: the character waits in the input
// register, then the token state update and result decode are worked out
// combinationally into the output register. Characters with no result are
// absorbed. A two-entry output buffer keeps input flowing in an output stall
// until its skid entry fills; s_axis_tready then falls until a result is taken.
module quoted_block_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [0] char_valid, [8:1] out_char, [16:9] token_level
	output logic [2:0]  m_axis_tuser,  // [2:0] token_type
	output logic        m_axis_tlast   // token_done
);

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          room;
	logic          step;
	logic          res_valid;
	qbt_pkg::res_t res;
	qbt_pkg::res_t out_res;

	assign s_axis_tready = !valid_s1 || room;
	assign step          = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
		end
	end

	qbt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_char   (char_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	qbt_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_data   (res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_data  (out_res),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = {7'd0, out_res.token_level, out_res.out_char, out_res.char_valid};
	assign m_axis_tuser = out_res.token_type;
	assign m_axis_tlast = out_res.token_done;

`ifndef ASSERT_OFF
	a_plain_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |->
			(m_axis_tdata[0] && m_axis_tuser == qbt_pkg::TOK_KEY &&
			m_axis_tdata[16:9] == 8'd0))
		else $error("echo result without a character or with token fields set");

	a_empty_char: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tdata[8:1] == 8'd0)
		else $error("character field set without char_valid");
`endif

endmodule

// ===== hdl/qbt_core.sv =====
// ----------------------------------------------------------------------------
// Quoted block tokenizer core
// Holds the token state and works out the result of one character.
// ----------------------------------------------------------------------------
module qbt_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         in_char,
	output logic               res_valid,
	output qbt_pkg::res_t      res
);

	qbt_pkg::phase_t               phase_q;
	logic                          in_quotes_q;
	logic                          pair_pending_q;
	logic [qbt_pkg::LEVEL_BITS-1:0] nest_level_q;
	qbt_pkg::tok_t                 kind_q;

	qbt_pkg::phase_t               phase_nxt;
	logic                          in_quotes_nxt;
	logic                          pair_pending_nxt;
	logic [qbt_pkg::LEVEL_BITS-1:0] nest_level_nxt;
	qbt_pkg::tok_t                 kind_nxt;

	logic is_q, is_lp, is_rp, is_pu, is_nul, is_an;
	logic q_new, sign, taken, active;
	logic idle_punct, fall, end_tok, app, count_lvl, rep_minus, rep_plus;
	qbt_pkg::phase_t ph_eff;
	qbt_pkg::tok_t   kind_eff, kind_punct, k_end;
	logic [qbt_pkg::LEVEL_BITS-1:0] lvl_val;
	logic [7:0] rep;

	function automatic logic [7:0] level_report(
		input logic [qbt_pkg::LEVEL_BITS-1:0] l,
		input logic minus,
		input logic plus
	);
		logic [qbt_pkg::REP_W-1:0] e;
		logic [qbt_pkg::REP_W-1:0] r;
		e = qbt_pkg::REP_W'(l);
		if (minus) begin
			r = e - qbt_pkg::REP_W'(1);
		end else if (plus) begin
			r = e + qbt_pkg::REP_W'(1);
		end else begin
			r = e;
		end
		if ((minus && l == '0) || r > qbt_pkg::REP_W'(255)) begin
			return 8'hFF;
		end
		return r[7:0];
	endfunction

	assign is_q   = (in_char == qbt_pkg::CH_QUOTE);
	assign is_lp  = (in_char == qbt_pkg::CH_LPAREN);
	assign is_rp  = (in_char == qbt_pkg::CH_RPAREN);
	assign is_pu  = is_lp || is_rp || in_char == qbt_pkg::CH_SEMI || in_char == qbt_pkg::CH_EQ;
	assign is_nul = (in_char == qbt_pkg::CH_NUL);
	assign is_an  = (in_char inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});

	assign q_new  = in_quotes_q ^ is_q;
	assign sign   = q_new ? is_q : (is_q || is_pu || is_nul);
	assign taken  = q_new || is_an || is_q || is_pu || is_nul;
	assign active = step && taken;

	always_comb begin
		ph_eff     = phase_q;
		kind_eff   = kind_q;
		idle_punct = 1'b0;
		fall       = 1'b0;
		kind_punct = qbt_pkg::TOK_BLOCK;
		if (phase_q == qbt_pkg::PH_IDLE) begin
			if (is_q) begin
				ph_eff   = pair_pending_q ? qbt_pkg::PH_VALUE : qbt_pkg::PH_KEY;
				kind_eff = pair_pending_q ? qbt_pkg::TOK_VALUE : qbt_pkg::TOK_KEY;
				fall     = 1'b1;
			end else if (is_an) begin
				ph_eff   = qbt_pkg::PH_VALUE;
				kind_eff = qbt_pkg::TOK_VALUE;
				fall     = 1'b1;
			end else if (is_pu) begin
				idle_punct = 1'b1;
			end
		end else begin
			fall = 1'b1;
		end
		if (in_char == qbt_pkg::CH_SEMI) begin
			kind_punct = qbt_pkg::TOK_SEMI;
		end else if (in_char == qbt_pkg::CH_EQ) begin
			kind_punct = qbt_pkg::TOK_EQ;
		end

		app     = !(ph_eff == qbt_pkg::PH_VALUE && is_nul && !q_new);
		end_tok = fall && sign && !q_new;
		k_end   = (ph_eff == qbt_pkg::PH_KEY && pair_pending_q) ? qbt_pkg::TOK_VALUE : kind_eff;

		count_lvl = idle_punct || (fall && ph_eff == qbt_pkg::PH_VALUE);
		lvl_val   = nest_level_q;
		if (count_lvl && is_lp && nest_level_q < qbt_pkg::LEVEL_MAX) begin
			lvl_val = nest_level_q + qbt_pkg::LEVEL_BITS'(1);
		end else if (count_lvl && is_rp && nest_level_q != '0) begin
			lvl_val = nest_level_q - qbt_pkg::LEVEL_BITS'(1);
		end

		rep_minus = (idle_punct && is_lp) || (end_tok && k_end == qbt_pkg::TOK_VALUE && is_lp);
		rep_plus  = end_tok && k_end == qbt_pkg::TOK_VALUE && is_rp;
		rep       = level_report(lvl_val, rep_minus, rep_plus);
	end

	always_comb begin
		phase_nxt        = phase_q;
		in_quotes_nxt    = in_quotes_q;
		pair_pending_nxt = pair_pending_q;
		nest_level_nxt   = nest_level_q;
		kind_nxt         = kind_q;
		if (active) begin
			in_quotes_nxt  = q_new;
			nest_level_nxt = lvl_val;
			if (idle_punct) begin
				kind_nxt         = kind_punct;
				pair_pending_nxt = (kind_punct == qbt_pkg::TOK_EQ);
			end else if (fall) begin
				phase_nxt = end_tok ? qbt_pkg::PH_IDLE : ph_eff;
				kind_nxt  = end_tok ? k_end : kind_eff;
				if (end_tok && k_end != qbt_pkg::TOK_EQ) begin
					pair_pending_nxt = 1'b0;
				end
			end
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (active) begin
			if (idle_punct) begin
				res_valid       = 1'b1;
				res.char_valid  = 1'b1;
				res.out_char    = in_char;
				res.token_done  = 1'b1;
				res.token_type  = kind_punct;
				res.token_level = rep;
			end else if (fall && end_tok) begin
				res_valid       = 1'b1;
				res.char_valid  = app;
				res.out_char    = app ? in_char : 8'h00;
				res.token_done  = 1'b1;
				res.token_type  = k_end;
				res.token_level = rep;
			end else if (fall) begin
				res_valid      = app;
				res.char_valid = 1'b1;
				res.out_char   = in_char;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= qbt_pkg::PH_IDLE;
			in_quotes_q    <= 1'b0;
			pair_pending_q <= 1'b0;
			nest_level_q   <= '0;
			kind_q         <= qbt_pkg::TOK_KEY;
		end else begin
			phase_q        <= phase_nxt;
			in_quotes_q    <= in_quotes_nxt;
			pair_pending_q <= pair_pending_nxt;
			nest_level_q   <= nest_level_nxt;
			kind_q         <= kind_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_level_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		nest_level_q <= qbt_pkg::LEVEL_MAX)
		else $error("nesting level above its ceiling");

	a_drop_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !taken) |=> $stable(phase_q) && $stable(nest_level_q) && $stable(in_quotes_q))
		else $error("dropped character changed the state");
`endif

endmodule

// ===== hdl/qbt_skid.sv =====
// ----------------------------------------------------------------------------
// Quoted block tokenizer result buffer
// Output register with a skid stage, so a stalled result does not stop input.
// ----------------------------------------------------------------------------
module qbt_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  qbt_pkg::res_t in_data,
	output logic          room,
	output logic          out_valid,
	output qbt_pkg::res_t out_data,
	input  logic          out_ready
);

	logic          out_valid_q;
	qbt_pkg::res_t out_data_q;
	logic          skid_valid_q;
	qbt_pkg::res_t skid_data_q;

	assign room      = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid) begin
			skid_data_q <= in_data;
		end
	end

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a result while the output register is empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !in_valid)
		else $error("result pushed while the buffer is full");
`endif

endmodule
